### sv/parallelepiped_pixel_classifier_defines.svh
// Assertion macros shared by the classifier RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef PARALLELEPIPED_PIXEL_CLASSIFIER_DEFINES_SVH
`define PARALLELEPIPED_PIXEL_CLASSIFIER_DEFINES_SVH

// Concurrent property check that reports through $error.
`define PPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check of a condition that must hold at every clock edge.
`define PPC_ASSERT_COMB(label, expr, msg) \
  `PPC_ASSERT(label, (expr), msg)

`endif

### sv/ppc_pkg.sv
// Package for the parallelepiped pixel classifier: field widths, codes and types.
// It has no dependencies.
`timescale 1ns / 1ps

package ppc_pkg;

  localparam int IN_BANDS    = 4;
  localparam int SAMPLE_W    = 16;
  localparam int BOUND_W     = 18;
  localparam int CODE_W      = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  typedef enum logic [1:0] {
    OUTCOME_MATCH  = 2'd0,
    OUTCOME_NONE   = 2'd1,
    OUTCOME_NODATA = 2'd2
  } outcome_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NO_CLASS      = 3'd0,
    REG_NODATA_RESULT = 3'd1,
    REG_NODATA_EN     = 3'd2,
    REG_NODATA_SAMPLE = 3'd3,
    REG_BAND_COUNT    = 3'd4,
    REG_CLASS_COUNT   = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } ppc_state_e;

endpackage

### sv/ppc_ram.sv
// Generic simple dual-port RAM: one write port and one read port with registered read data.
// It has no dependencies.
`timescale 1ns / 1ps

module ppc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/parallelepiped_pixel_classifier.sv
// Parallelepiped pixel classifier: a bound table in RAM scanned by one shared box comparator.
// Depends on ppc_pkg, ppc_ram and parallelepiped_pixel_classifier_defines.svh.
//
// Usage. The input channel carries two kinds of transaction. A load (opcode 0) writes
// the lower and upper bound of one class and band and the class code of that class;
// it completes in the cycle it is accepted and produces no result. A classify
// (opcode 1) carries up to four band samples and produces exactly one result on the
// output channel: the class code, the outcome and a copy of the last-pixel flag.
// The configuration channel is always ready; the user must write it only while the block
// is idle; the block does not enforce this. A classify walks the table one class-band
// pair per cycle through the single read port of the bound RAM, over N tested classes
// and B active bands, then through the drain and finish states; a no-data pixel or N of
// zero goes straight to finish. The input is not ready from the acceptance of a classify
// until its result is in the output register; the next item is taken in the cycle after.
// A finished result waits in the output register while a new item is accepted; if
// the receiver still stalls when the next result is ready, the block holds it and
// stays busy until the output register frees.
// Reset clears the sequencer and configuration registers; the band count resets to 4.
// The bound and code tables are not cleared and must be loaded before they are used.
`timescale 1ns / 1ps
`include "parallelepiped_pixel_classifier_defines.svh"

module parallelepiped_pixel_classifier import ppc_pkg::*; #(
  parameter int CLASSES     = 64,
  parameter int BANDS       = 4,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,

  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,

  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   opcode_i,
  input  logic [5:0]             entry_class_i,
  input  logic [1:0]             entry_band_i,
  input  logic signed [BOUND_W-1:0] entry_lower_i,
  input  logic signed [BOUND_W-1:0] entry_upper_i,
  input  logic [CODE_W-1:0]      entry_class_id_i,
  input  logic [SAMPLE_W-1:0]    sample_0_i,
  input  logic [SAMPLE_W-1:0]    sample_1_i,
  input  logic [SAMPLE_W-1:0]    sample_2_i,
  input  logic [SAMPLE_W-1:0]    sample_3_i,
  input  logic                   last_pixel_i,

  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [CODE_W-1:0]      pixel_class_o,
  output logic [1:0]             outcome_o,
  output logic                   last_out_o
);

  localparam int ENTRIES   = CLASSES * BANDS;
  localparam int AW        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW        = (CLASSES > 1) ? $clog2(CLASSES) : 1;
  localparam int BW        = $clog2(IN_BANDS);
  localparam int EFF_BANDS = (BANDS < IN_BANDS) ? BANDS : IN_BANDS;
  localparam int MASK_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((33'd1 << MASK_BITS) - 33'd1);
  localparam logic [8:0] CLASSES_W   = 9'(CLASSES);
  localparam logic [2:0] EFF_BANDS_W = 3'(EFF_BANDS);

  // Configuration registers.
  logic [CODE_W-1:0]   no_class_value_q;
  logic [CODE_W-1:0]   nodata_result_value_q;
  logic                nodata_check_enable_q;
  logic [SAMPLE_W-1:0] nodata_sample_q;
  logic [2:0]          band_count_q;
  logic [6:0]          class_count_q;

  // Sequencer and datapath.
  ppc_state_e          state_q, state_d;
  logic                issue;
  logic                finish_xfer;
  logic [SAMPLE_W-1:0] sample_q [IN_BANDS];
  logic                last_q;
  logic [BW-1:0]       nb_last_q;
  logic [CW-1:0]       nc_last_q;
  logic [CW-1:0]       cls_idx_q;
  logic [BW-1:0]       band_idx_q;
  logic                pend_valid_q;
  logic [BW-1:0]       pend_band_q;
  logic                pend_first_q;
  logic                pend_last_q;
  logic                inside_q;
  logic [CODE_W-1:0]   res_class_q;
  outcome_e            res_outcome_q;
  logic                out_valid_q;
  logic [CODE_W-1:0]   out_class_q;
  outcome_e            out_outcome_q;
  logic                out_last_q;

  logic                in_fire;
  logic                load_fire;
  logic                cls_fire;
  logic [8:0]          nc_full;
  logic [2:0]          nb_full;
  logic [BW-1:0]       nb_last;
  logic [CW-1:0]       nc_last;
  logic [SAMPLE_W-1:0] sample_in [IN_BANDS];
  logic [SAMPLE_W-1:0] nodata_cmp;
  logic                nodata_hit;
  logic                load_ok;
  logic                bound_we;
  logic                code_we;
  logic [31:0]         wr_full;
  logic [31:0]         rd_full;
  logic [31:0]         wr_cls_full;
  logic [2*BOUND_W-1:0] bound_rd;
  logic [CODE_W-1:0]   code_rd;
  logic signed [BOUND_W-1:0] lower_rd;
  logic signed [BOUND_W-1:0] upper_rd;
  logic signed [BOUND_W-1:0] sample_ext;
  logic                in_box;
  logic                inside_run;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign load_fire   = in_fire && (opcode_i == OP_LOAD);
  assign cls_fire    = in_fire && (opcode_i == OP_CLASSIFY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      no_class_value_q      <= '0;
      nodata_result_value_q <= '0;
      nodata_check_enable_q <= 1'b0;
      nodata_sample_q       <= '0;
      band_count_q          <= 3'd4;
      class_count_q         <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_NO_CLASS:      no_class_value_q      <= cfg_data_i[CODE_W-1:0];
        REG_NODATA_RESULT: nodata_result_value_q <= cfg_data_i[CODE_W-1:0];
        REG_NODATA_EN:     nodata_check_enable_q <= cfg_data_i[0];
        REG_NODATA_SAMPLE: nodata_sample_q       <= cfg_data_i;
        REG_BAND_COUNT:    band_count_q          <= cfg_data_i[2:0];
        REG_CLASS_COUNT:   class_count_q         <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  assign sample_in[0] = sample_0_i & SAMPLE_MASK;
  assign sample_in[1] = sample_1_i & SAMPLE_MASK;
  assign sample_in[2] = sample_2_i & SAMPLE_MASK;
  assign sample_in[3] = sample_3_i & SAMPLE_MASK;
  assign nodata_cmp   = nodata_sample_q & SAMPLE_MASK;

  always_comb begin
    nc_full = ({2'b00, class_count_q} > CLASSES_W) ? CLASSES_W : {2'b00, class_count_q};
    if (band_count_q == 3'd0) begin
      nb_full = 3'd1;
    end else if (band_count_q > EFF_BANDS_W) begin
      nb_full = EFF_BANDS_W;
    end else begin
      nb_full = band_count_q;
    end
    nb_last = BW'(nb_full - 3'd1);
    nc_last = CW'(nc_full - 9'd1);
  end

  always_comb begin
    nodata_hit = nodata_check_enable_q;
    for (int b = 0; b < IN_BANDS; b++) begin
      if ((BW'(b) <= nb_last) && (sample_in[b] != nodata_cmp)) begin
        nodata_hit = 1'b0;
      end
    end
  end

  assign load_ok     = (32'(entry_class_i) < 32'(CLASSES)) && (32'(entry_band_i) < 32'(BANDS));
  assign bound_we    = load_fire && load_ok;
  assign code_we     = bound_we;
  assign wr_full     = 32'(entry_class_i) * 32'(BANDS) + 32'(entry_band_i);
  assign wr_cls_full = 32'(entry_class_i);
  assign rd_full     = 32'(cls_idx_q) * 32'(BANDS) + 32'(band_idx_q);

  ppc_ram #(
    .WIDTH(2 * BOUND_W),
    .DEPTH(ENTRIES)
  ) u_bound_ram (
    .clk_i   (clk_i),
    .we_i    (bound_we),
    .waddr_i (wr_full[AW-1:0]),
    .wdata_i ({entry_lower_i, entry_upper_i}),
    .re_i    (issue),
    .raddr_i (rd_full[AW-1:0]),
    .rdata_o (bound_rd)
  );

  ppc_ram #(
    .WIDTH(CODE_W),
    .DEPTH(CLASSES)
  ) u_code_ram (
    .clk_i   (clk_i),
    .we_i    (code_we),
    .waddr_i (wr_cls_full[CW-1:0]),
    .wdata_i (entry_class_id_i),
    .re_i    (issue),
    .raddr_i (cls_idx_q),
    .rdata_o (code_rd)
  );

  // Shared box comparator: one class-band pair per cycle.
  assign lower_rd   = bound_rd[2*BOUND_W-1:BOUND_W];
  assign upper_rd   = bound_rd[BOUND_W-1:0];
  assign sample_ext = {{(BOUND_W - SAMPLE_W){1'b0}}, sample_q[pend_band_q]};
  assign in_box     = (sample_ext >= lower_rd) && (sample_ext <= upper_rd);
  assign inside_run = pend_first_q ? in_box : (inside_q && in_box);

  always_comb begin
    state_d     = state_q;
    issue       = 1'b0;
    finish_xfer = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cls_fire) begin
          state_d = (nodata_hit || (nc_full == 9'd0)) ? ST_FINISH : ST_RUN;
        end
      end
      ST_RUN: begin
        issue = 1'b1;
        if ((band_idx_q == nb_last_q) && (cls_idx_q == nc_last_q)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          finish_xfer = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      cls_idx_q    <= '0;
      band_idx_q   <= '0;
    end else begin
      state_q      <= state_d;
      pend_valid_q <= issue;
      if (finish_xfer) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cls_fire) begin
        cls_idx_q  <= '0;
        band_idx_q <= '0;
      end else if (issue) begin
        if (band_idx_q == nb_last_q) begin
          band_idx_q <= '0;
          if (cls_idx_q != nc_last_q) begin
            cls_idx_q <= cls_idx_q + CW'(1);
          end
        end else begin
          band_idx_q <= band_idx_q + BW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cls_fire) begin
      sample_q    <= sample_in;
      last_q      <= last_pixel_i;
      nb_last_q   <= nb_last;
      nc_last_q   <= nc_last;
      if (nodata_hit) begin
        res_class_q   <= nodata_result_value_q;
        res_outcome_q <= OUTCOME_NODATA;
      end else begin
        res_class_q   <= no_class_value_q;
        res_outcome_q <= OUTCOME_NONE;
      end
    end
    if (issue) begin
      pend_band_q  <= band_idx_q;
      pend_first_q <= (band_idx_q == '0);
      pend_last_q  <= (band_idx_q == nb_last_q);
    end
    if (pend_valid_q) begin
      inside_q <= inside_run;
      if (pend_last_q && inside_run && (code_rd != no_class_value_q)) begin
        res_class_q   <= code_rd;
        res_outcome_q <= OUTCOME_MATCH;
      end
    end
    if (finish_xfer) begin
      out_class_q   <= res_class_q;
      out_outcome_q <= res_outcome_q;
      out_last_q    <= last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_class_o = out_class_q;
  assign outcome_o     = out_outcome_q;
  assign last_out_o    = out_last_q;

  `PPC_ASSERT(a_pend_from_run, pend_valid_q |-> ($past(state_q) == ST_RUN),
              "compare without a read issued in RUN")
  `PPC_ASSERT(a_out_from_finish, $rose(out_valid_q) |-> ($past(state_q) == ST_FINISH),
              "result appeared outside FINISH")
  `PPC_ASSERT_COMB(a_idx_in_range,
                   (state_q != ST_RUN) ||
                   ((band_idx_q <= nb_last_q) && (cls_idx_q <= nc_last_q)),
                   "table scan index out of range")
  `PPC_ASSERT(a_match_not_noclass,
              (out_valid_q && (out_outcome_q == OUTCOME_MATCH)) |->
              (out_class_q != no_class_value_q),
              "matched class carries the no-class code")

endmodule

### tb/tb_parallelepiped_pixel_classifier.sv
// Self-checking testbench for parallelepiped_pixel_classifier: box-table loads and pixel
// classification are predicted in a scoreboard class and checked field by field.
// Depends on ppc_pkg and the classifier RTL.
`timescale 1ns / 1ps

module tb_parallelepiped_pixel_classifier;
  import ppc_pkg::*;

  localparam int TABLE_CLASSES = 64;
  localparam int TABLE_BANDS   = 4;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 40;
  localparam int RANDOM_PHASES = 14;

  typedef struct {
    logic                      op;
    logic [5:0]                cls;
    logic [1:0]                band;
    logic signed [BOUND_W-1:0] lo;
    logic signed [BOUND_W-1:0] hi;
    logic [CODE_W-1:0]         code;
    logic [3:0][SAMPLE_W-1:0]  smp;
    logic                      last;
  } ppc_item_t;

  typedef struct {
    logic [CODE_W-1:0] pixel_class;
    outcome_e          outcome;
    logic              last;
  } label_t;

  typedef struct {
    logic [7:0]  no_class;
    logic [7:0]  nodata_res;
    logic        nodata_en;
    logic [15:0] nodata_smp;
    logic [2:0]  band_cnt;
    logic [6:0]  class_cnt;
  } reg_set_t;

  class label_scoreboard;
    int          lo_tab[TABLE_CLASSES*TABLE_BANDS];
    int          hi_tab[TABLE_CLASSES*TABLE_BANDS];
    logic [7:0]  code_tab[TABLE_CLASSES];
    logic [7:0]  no_class;
    logic [7:0]  nodata_res;
    logic        nodata_en;
    logic [15:0] nodata_smp;
    logic [2:0]  band_cnt;
    logic [6:0]  class_cnt;
    label_t      pending[$];
    int          errors;
    int          loads;
    int          matched;
    int          unmatched;
    int          nodata_hits;

    function new();
      no_class   = '0;
      nodata_res = '0;
      nodata_en  = 1'b0;
      nodata_smp = '0;
      band_cnt   = 3'd4;
      class_cnt  = '0;
    endfunction

    function int active_bands();
      int n;
      n = band_cnt;
      if (n < 1) n = 1;
      if (n > IN_BANDS) n = IN_BANDS;
      return n;
    endfunction

    function int active_classes();
      int n;
      n = class_cnt;
      if (n > TABLE_CLASSES) n = TABLE_CLASSES;
      return n;
    endfunction

    function void write_reg(cfg_reg_e r, logic [CFG_DATA_W-1:0] v);
      case (r)
        REG_NO_CLASS:      no_class   = v[7:0];
        REG_NODATA_RESULT: nodata_res = v[7:0];
        REG_NODATA_EN:     nodata_en  = v[0];
        REG_NODATA_SAMPLE: nodata_smp = v[15:0];
        REG_BAND_COUNT:    band_cnt   = v[2:0];
        REG_CLASS_COUNT:   class_cnt  = v[6:0];
        default: ;
      endcase
    endfunction

    function label_t classify(ppc_item_t it);
      label_t res;
      int     nb;
      int     nc;
      bit     nd;
      bit     hit;
      int     idx;
      nb = active_bands();
      nc = active_classes();
      res.last = it.last;
      nd = nodata_en;
      for (int b = 0; b < nb; b++)
        if (it.smp[b] != nodata_smp) nd = 1'b0;
      if (nd) begin
        res.pixel_class = nodata_res;
        res.outcome     = OUTCOME_NODATA;
      end else begin
        res.pixel_class = no_class;
        res.outcome     = OUTCOME_NONE;
        for (int c = 0; c < nc; c++) begin
          hit = 1'b1;
          for (int b = 0; b < nb; b++) begin
            idx = c * TABLE_BANDS + b;
            if (int'(it.smp[b]) < lo_tab[idx] || int'(it.smp[b]) > hi_tab[idx]) hit = 1'b0;
          end
          if (hit && code_tab[c] != no_class) begin
            res.pixel_class = code_tab[c];
            res.outcome     = OUTCOME_MATCH;
          end
        end
      end
      return res;
    endfunction

    function void note_input(ppc_item_t it);
      int idx;
      if (it.op == OP_LOAD) begin
        idx = it.cls * TABLE_BANDS + it.band;
        lo_tab[idx] = int'(it.lo);
        hi_tab[idx] = int'(it.hi);
        code_tab[it.cls] = it.code;
        loads++;
      end else begin
        pending.insert(pending.size(), classify(it));
      end
    endfunction

    function void check_result(logic [7:0] pc, logic [1:0] oc, logic lst);
      label_t exp_lbl;
      if (pending.size() == 0) begin
        $error("unexpected result: pixel_class %0d outcome %0d", pc, oc);
        errors++;
        return;
      end
      exp_lbl = pending.pop_front();
      if (pc !== exp_lbl.pixel_class) begin
        $error("pixel_class: expected %0d, actual %0d", exp_lbl.pixel_class, pc);
        errors++;
      end
      if (oc !== exp_lbl.outcome) begin
        $error("outcome: expected %0d, actual %0d", exp_lbl.outcome, oc);
        errors++;
      end
      if (lst !== exp_lbl.last) begin
        $error("last_out: expected %0d, actual %0d", exp_lbl.last, lst);
        errors++;
      end
      case (exp_lbl.outcome)
        OUTCOME_MATCH:  matched++;
        OUTCOME_NODATA: nodata_hits++;
        default:        unmatched++;
      endcase
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [CFG_INDEX_W-1:0]    cfg_index_i;
  logic [CFG_DATA_W-1:0]     cfg_data_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic                      opcode_i;
  logic [5:0]                entry_class_i;
  logic [1:0]                entry_band_i;
  logic signed [BOUND_W-1:0] entry_lower_i;
  logic signed [BOUND_W-1:0] entry_upper_i;
  logic [CODE_W-1:0]         entry_class_id_i;
  logic [SAMPLE_W-1:0]       sample_0_i;
  logic [SAMPLE_W-1:0]       sample_1_i;
  logic [SAMPLE_W-1:0]       sample_2_i;
  logic [SAMPLE_W-1:0]       sample_3_i;
  logic                      last_pixel_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic [CODE_W-1:0]         pixel_class_o;
  logic [1:0]                outcome_o;
  logic                      last_out_o;

  label_scoreboard sb = new();
  bit              tx_idle;
  bit              rx_idle;
  int              rx_hold_cycles;
  int              settings_applied;

  parallelepiped_pixel_classifier #(
    .CLASSES    (TABLE_CLASSES),
    .BANDS      (TABLE_BANDS),
    .SAMPLE_BITS(SAMPLE_W)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .opcode_i        (opcode_i),
    .entry_class_i   (entry_class_i),
    .entry_band_i    (entry_band_i),
    .entry_lower_i   (entry_lower_i),
    .entry_upper_i   (entry_upper_i),
    .entry_class_id_i(entry_class_id_i),
    .sample_0_i      (sample_0_i),
    .sample_1_i      (sample_1_i),
    .sample_2_i      (sample_2_i),
    .sample_3_i      (sample_3_i),
    .last_pixel_i    (last_pixel_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .pixel_class_o   (pixel_class_o),
    .outcome_o       (outcome_o),
    .last_out_o      (last_out_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic int pause_len();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(3, 1);
    if (r < 95) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic int rand_bound();
    return int'($urandom_range(196607)) - 65536;
  endfunction

  function automatic ppc_item_t random_item(logic op);
    ppc_item_t it;
    it.op   = op;
    it.cls  = 6'($urandom_range(63));
    it.band = 2'($urandom_range(3));
    it.lo   = BOUND_W'(rand_bound());
    it.hi   = BOUND_W'(rand_bound());
    it.code = 8'($urandom_range(255));
    for (int b = 0; b < IN_BANDS; b++) it.smp[b] = 16'($urandom_range(65535));
    it.last = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic ppc_item_t mk_load(int c, int b, int lo, int hi, int code);
    ppc_item_t it;
    it = random_item(OP_LOAD);
    it.cls  = 6'(c);
    it.band = 2'(b);
    it.lo   = BOUND_W'(lo);
    it.hi   = BOUND_W'(hi);
    it.code = 8'(code);
    return it;
  endfunction

  function automatic ppc_item_t mk_pixel(int s0, int s1, int s2, int s3, bit last);
    ppc_item_t it;
    it = random_item(OP_CLASSIFY);
    it.smp[0] = 16'(s0);
    it.smp[1] = 16'(s1);
    it.smp[2] = 16'(s2);
    it.smp[3] = 16'(s3);
    it.last   = last;
    return it;
  endfunction

  function automatic ppc_item_t rand_load(int nc);
    ppc_item_t it;
    int        r;
    int        lo;
    int        hi;
    int        center;
    int        hw;
    it = random_item(OP_LOAD);
    if (nc > 0 && $urandom_range(1) == 1) it.cls = 6'($urandom_range(nc - 1));
    r = $urandom_range(99);
    if (r < 5) begin
      lo = -65536;
      hi = 131071;
    end else if (r < 10) begin
      hi = $urandom_range(65535);
      lo = hi + 1 + $urandom_range(500);
    end else if (r < 15) begin
      lo = -int'($urandom_range(65536));
      hi = $urandom_range(65535);
    end else if (r < 20) begin
      lo = $urandom_range(65535);
      hi = 65535 + $urandom_range(65536);
    end else begin
      center = 1000 + $urandom_range(7) * 8000 + $urandom_range(3000);
      hw = $urandom_range(4000);
      lo = center - hw;
      hi = center + hw;
    end
    it.lo = BOUND_W'(lo);
    it.hi = BOUND_W'(hi);
    it.code = ($urandom_range(7) == 0) ? sb.no_class : 8'($urandom_range(255));
    return it;
  endfunction

  function automatic ppc_item_t rand_pixel();
    ppc_item_t it;
    int        nc;
    int        nb;
    int        c;
    int        lo;
    int        hi;
    int        v;
    int        r;
    it = random_item(OP_CLASSIFY);
    nc = sb.active_classes();
    nb = sb.active_bands();
    r = $urandom_range(99);
    if (r < 15) begin
      for (int b = 0; b < nb; b++) it.smp[b] = sb.nodata_smp;
    end else if (r < 75 && nc > 0) begin
      c = $urandom_range(nc - 1);
      for (int b = 0; b < IN_BANDS; b++) begin
        lo = sb.lo_tab[c * TABLE_BANDS + b];
        hi = sb.hi_tab[c * TABLE_BANDS + b];
        if (lo < 0) lo = 0;
        if (hi > 65535) hi = 65535;
        if (lo <= hi) begin
          case ($urandom_range(9))
            0:       v = lo;
            1:       v = hi;
            2:       v = lo - 1;
            3:       v = hi + 1;
            default: v = $urandom_range(hi, lo);
          endcase
          if (v >= 0 && v <= 65535) it.smp[b] = 16'(v);
        end
      end
    end else if (r < 82) begin
      for (int b = 0; b < IN_BANDS; b++) it.smp[b] = ($urandom_range(1) == 1) ? 16'hFFFF : 16'h0;
    end
    return it;
  endfunction

  task automatic send_item(ppc_item_t it);
    int gap;
    in_valid_i       <= 1'b1;
    opcode_i         <= it.op;
    entry_class_i    <= it.cls;
    entry_band_i     <= it.band;
    entry_lower_i    <= it.lo;
    entry_upper_i    <= it.hi;
    entry_class_id_i <= it.code;
    sample_0_i       <= it.smp[0];
    sample_1_i       <= it.smp[1];
    sample_2_i       <= it.smp[2];
    sample_3_i       <= it.smp[3];
    last_pixel_i     <= it.last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(it);
    gap = (tx_idle && $urandom_range(99) >= 60) ? pause_len() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic cfg_put(cfg_reg_e r, logic [CFG_DATA_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(r, v);
  endtask

  task automatic program_regs(reg_set_t s);
    cfg_put(REG_NO_CLASS, CFG_DATA_W'(s.no_class));
    cfg_put(REG_NODATA_RESULT, CFG_DATA_W'(s.nodata_res));
    cfg_put(REG_NODATA_EN, CFG_DATA_W'(s.nodata_en));
    cfg_put(REG_NODATA_SAMPLE, CFG_DATA_W'(s.nodata_smp));
    cfg_put(REG_BAND_COUNT, CFG_DATA_W'(s.band_cnt));
    cfg_put(REG_CLASS_COUNT, CFG_DATA_W'(s.class_cnt));
    cfg_valid_i <= 1'b0;
    settings_applied++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int n;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_cycles > 0) begin
        n = rx_hold_cycles;
        rx_hold_cycles = 0;
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (rx_idle && $urandom_range(99) < 25) begin
        out_ready_i <= 1'b0;
        repeat (pause_len()) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(pixel_class_o, outcome_o, last_out_o);
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_parallelepiped_pixel_classifier: done, errors");
    $finish;
  end

  initial begin
    reg_set_t s;
    int       n;
    rst_ni           <= 1'b0;
    cfg_valid_i      <= 1'b0;
    cfg_index_i      <= '0;
    cfg_data_i       <= '0;
    in_valid_i       <= 1'b0;
    opcode_i         <= OP_LOAD;
    entry_class_i    <= '0;
    entry_band_i     <= '0;
    entry_lower_i    <= '0;
    entry_upper_i    <= '0;
    entry_class_id_i <= '0;
    sample_0_i       <= '0;
    sample_1_i       <= '0;
    sample_2_i       <= '0;
    sample_3_i       <= '0;
    last_pixel_i     <= 1'b0;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    rx_hold_cycles = 0;
    settings_applied = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With the reset settings no class is tested, so every pixel gets the no-class code.
    send_item(mk_pixel(0, 0, 0, 0, 1'b1));
    send_item(mk_pixel(65535, 65535, 65535, 65535, 1'b0));
    for (int b = 0; b < TABLE_BANDS; b++) begin
      send_item(mk_load(0, b, 100, 200, 5));
      send_item(mk_load(1, b, -65536, 131071, 9));
      send_item(mk_load(2, b, 500, 400, 7));
    end
    settle();
    s = '{no_class: 8'd9, nodata_res: 8'hAA, nodata_en: 1'b1, nodata_smp: 16'hFFFF,
          band_cnt: 3'd4, class_cnt: 7'd3};
    program_regs(s);
    send_item(mk_pixel(150, 150, 150, 150, 1'b1));
    send_item(mk_pixel(201, 201, 201, 201, 1'b0));
    send_item(mk_pixel(65535, 65535, 65535, 65535, 1'b1));
    send_item(mk_pixel(65535, 65535, 65535, 150, 1'b0));
    send_item(mk_pixel(100, 200, 100, 200, 1'b1));
    settle();
    s = '{no_class: 8'd0, nodata_res: 8'h55, nodata_en: 1'b1, nodata_smp: 16'h0,
          band_cnt: 3'd0, class_cnt: 7'd3};
    program_regs(s);
    send_item(mk_pixel(0, 1, 2, 3, 1'b0));
    send_item(mk_pixel(150, 65535, 65535, 65535, 1'b1));
    settle();
    s.band_cnt = 3'd7;
    program_regs(s);
    send_item(mk_pixel(150, 150, 150, 150, 1'b0));

    // Fill the whole table so that any class count may be tested from here on.
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    for (int c = 0; c < TABLE_CLASSES; c++)
      for (int b = 0; b < TABLE_BANDS; b++) begin
        ppc_item_t it;
        it = rand_load(0);
        it.cls  = 6'(c);
        it.band = 2'(b);
        send_item(it);
      end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      s.no_class   = ($urandom_range(1) == 1) ? sb.code_tab[$urandom_range(7)]
                                              : 8'($urandom_range(255));
      s.nodata_res = 8'($urandom_range(255));
      s.nodata_en  = 1'($urandom_range(1));
      s.nodata_smp = ($urandom_range(3) == 0) ? 16'($urandom_range(255))
                                              : 16'($urandom_range(65535));
      s.band_cnt   = 3'($urandom_range(7));
      s.class_cnt  = 7'($urandom_range(12));
      n = 135;
      if (p == 0) begin
        s = '{no_class: 8'hFF, nodata_res: 8'hFF, nodata_en: 1'b1, nodata_smp: 16'hFFFF,
              band_cnt: 3'd7, class_cnt: 7'd127};
        n = 30;
      end else if (p == 1) begin
        s = '{no_class: 8'h0, nodata_res: 8'h0, nodata_en: 1'b1, nodata_smp: 16'h0,
              band_cnt: 3'd0, class_cnt: 7'd0};
      end else if (p == 6) begin
        s.class_cnt = 7'($urandom_range(127, 64));
        n = 30;
      end
      program_regs(s);
      tx_idle = ($urandom_range(3) != 0);
      rx_idle = ($urandom_range(3) != 0);
      if (p == 2 || p == 4) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end
      if (p == 2) rx_hold_cycles = 300;
      for (int i = 0; i < n; i++) begin
        if (p == 3 && i == n / 2) begin
          in_valid_i <= 1'b0;
          do @(posedge clk_i); while (sb.pending.size() != 0);
        end
        if ($urandom_range(99) < 20)
          send_item(rand_load(sb.active_classes()));
        else
          send_item(rand_pixel());
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.pending.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending.size());
      sb.errors += sb.pending.size();
    end
    $display("Checked %0d pixels (%0d matched, %0d no class, %0d no-data) and %0d table loads.",
             sb.matched + sb.unmatched + sb.nodata_hits, sb.matched, sb.unmatched,
             sb.nodata_hits, sb.loads);
    $display("Register settings applied: %0d, extremes, output hold-off and drain included.",
             settings_applied);
    if (sb.errors == 0)
      $display("tb_parallelepiped_pixel_classifier: done, clean");
    else
      $display("tb_parallelepiped_pixel_classifier: done, errors");
    $finish;
  end

endmodule

### parallelepiped_pixel_classifier.f
+incdir+sv
sv/ppc_pkg.sv
sv/ppc_ram.sv
sv/parallelepiped_pixel_classifier.sv
tb/tb_parallelepiped_pixel_classifier.sv
